[hw/rtl/lspe_pkg.sv]
// ----------------------------------------------------------------------------
// lspe_pkg: line sensor position estimator shared types and constants
// Field widths, register reset values, register indexes and channel structs.
// ----------------------------------------------------------------------------
`default_nettype none

package lspe_pkg;

  localparam int unsigned SENSOR_COUNT = 8;
  localparam int unsigned RAW_WIDTH    = 16;

  localparam int unsigned CAL_W   = 16;
  localparam int unsigned THR_W   = 10;
  localparam int unsigned NORM_W  = 10;
  localparam int unsigned POS_W   = 13;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned IDX_W   = $clog2(SENSOR_COUNT);
  localparam int unsigned NORM_FULL = 1000;
  localparam int unsigned POS_FULL  = (SENSOR_COUNT - 1) * NORM_FULL;
  localparam int unsigned POS_MID   = POS_FULL / 2;
  localparam int unsigned WGT_W   = $clog2(POS_FULL + 1);
  localparam int unsigned TOTAL_W = $clog2(SENSOR_COUNT * NORM_FULL + 1);
  localparam int unsigned WSUM_W  = $clog2(NORM_FULL * NORM_FULL *
                                           (SENSOR_COUNT * (SENSOR_COUNT - 1) / 2) + 1);

  // shared divider: quotient below 2**QUO_W by construction
  localparam int unsigned NUM_W = RAW_WIDTH + NORM_W;
  localparam int unsigned DEN_W = CAL_W;
  localparam int unsigned QUO_W = POS_W;
  localparam int unsigned STEP_W = $clog2(QUO_W + 1);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CAL_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_MAX    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ONLINE_THR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_THR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DETECT_THR = 3'd4;

  localparam logic [CAL_W-1:0] CAL_MIN_RST    = 16'd180;
  localparam logic [CAL_W-1:0] CAL_MAX_RST    = 16'd3500;
  localparam logic [THR_W-1:0] ONLINE_THR_RST = 10'd200;
  localparam logic [THR_W-1:0] WEIGHT_THR_RST = 10'd100;
  localparam logic [THR_W-1:0] DETECT_THR_RST = 10'd600;

  typedef struct packed {
    logic [RAW_WIDTH-1:0] raw_7;
    logic [RAW_WIDTH-1:0] raw_6;
    logic [RAW_WIDTH-1:0] raw_5;
    logic [RAW_WIDTH-1:0] raw_4;
    logic [RAW_WIDTH-1:0] raw_3;
    logic [RAW_WIDTH-1:0] raw_2;
    logic [RAW_WIDTH-1:0] raw_1;
    logic [RAW_WIDTH-1:0] raw_0;
  } in_payload_t;

  typedef struct packed {
    logic [POS_W-1:0] line_position;
    logic             on_line;
    logic [CNT_W-1:0] detect_count;
    logic             at_crossing;
    logic             crossing_entered;
  } out_payload_t;

  typedef struct packed {
    logic [CAL_W-1:0] cal_min;
    logic [CAL_W-1:0] cal_max;
    logic [THR_W-1:0] online_thr;
    logic [THR_W-1:0] weight_thr;
    logic [THR_W-1:0] detect_thr;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic start;
    logic ack;
  } seq_ctl_t;

  function automatic logic [WGT_W-1:0] sensor_weight(input logic [IDX_W-1:0] idx);
    return WGT_W'(idx) * WGT_W'(NORM_FULL);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/lspe_div.sv]
// ----------------------------------------------------------------------------
// lspe_div: serial restoring divider
// One quotient bit per cycle; the numerator must be below den * 2**QUO_W.
// ----------------------------------------------------------------------------
`default_nettype none

module lspe_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lspe_pkg::div_req_t req,
  output lspe_pkg::div_rsp_t      rsp
);

  logic [lspe_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic [lspe_pkg::DEN_W-1:0]  rem_r, rem_nxt;
  logic [lspe_pkg::DEN_W-1:0]  den_r, den_nxt;
  logic [lspe_pkg::QUO_W-1:0]  low_r, low_nxt;
  logic [lspe_pkg::QUO_W-1:0]  quo_r, quo_nxt;
  logic                        done_r, done_nxt;
  logic [lspe_pkg::DEN_W:0]    trial;
  logic                        fits;

  assign trial = {rem_r, low_r[lspe_pkg::QUO_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    low_nxt  = low_r;
    quo_nxt  = quo_r;
    done_nxt = 1'b0;
    if (req.start) begin
      cnt_nxt = lspe_pkg::STEP_W'(lspe_pkg::QUO_W);
      rem_nxt = lspe_pkg::DEN_W'(req.num >> lspe_pkg::QUO_W);
      low_nxt = req.num[lspe_pkg::QUO_W-1:0];
      den_nxt = req.den;
    end else if (cnt_r != '0) begin
      rem_nxt = fits ? lspe_pkg::DEN_W'(trial - {1'b0, den_r})
                     : lspe_pkg::DEN_W'(trial);
      low_nxt = low_r << 1;
      quo_nxt = {quo_r[lspe_pkg::QUO_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      done_nxt = (cnt_r == lspe_pkg::STEP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    low_r <= low_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

`default_nettype wire

[hw/rtl/lspe_seq.sv]
// ----------------------------------------------------------------------------
// lspe_seq: frame sequencer
// Shifts readings out one sensor at a time, normalizes, accumulates the
// weighted sums and finishes position and crossing state.
// ----------------------------------------------------------------------------
`default_nettype none

module lspe_seq (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire lspe_pkg::seq_ctl_t    ctl,
  input  wire lspe_pkg::in_payload_t frame,
  input  wire lspe_pkg::cfg_t        cfg,
  output logic                       res_valid,
  output lspe_pkg::out_payload_t     result,
  output lspe_pkg::div_req_t         div_req,
  input  wire lspe_pkg::div_rsp_t    div_rsp
);

  localparam int unsigned SH_W = lspe_pkg::SENSOR_COUNT * lspe_pkg::RAW_WIDTH;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_NORM  = 3'd1;
  localparam logic [2:0] S_WAITN = 3'd2;
  localparam logic [2:0] S_ACC   = 3'd3;
  localparam logic [2:0] S_ADD   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;
  localparam logic [2:0] S_WAITP = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]                   state_r, state_nxt;
  logic [SH_W-1:0]              sh_r, sh_nxt;
  logic [lspe_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic [lspe_pkg::NORM_W-1:0]  v_r, v_nxt;
  logic [lspe_pkg::WSUM_W-1:0]  wprod_r, wprod_nxt;
  logic [lspe_pkg::WSUM_W-1:0]  wsum_r, wsum_nxt;
  logic [lspe_pkg::TOTAL_W-1:0] total_r, total_nxt;
  logic [lspe_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic                         online_r, online_nxt;
  logic [lspe_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic                         flag_r, flag_nxt;
  logic                         entered_r, entered_nxt;
  logic [lspe_pkg::NUM_W-1:0]   dnum_r, dnum_nxt;
  logic [lspe_pkg::DEN_W-1:0]   dden_r, dden_nxt;
  logic                         dstart_r, dstart_nxt;

  logic [lspe_pkg::RAW_WIDTH-1:0] raw;
  logic [lspe_pkg::RAW_WIDTH-1:0] diff;
  logic [lspe_pkg::CAL_W-1:0]     span;
  logic                           low_side;

  assign raw      = sh_r[lspe_pkg::RAW_WIDTH-1:0];
  assign diff     = raw - cfg.cal_min;
  assign span     = cfg.cal_max - cfg.cal_min;
  assign low_side = (cfg.cal_max <= cfg.cal_min) || (raw <= cfg.cal_min);

  always_comb begin
    state_nxt   = state_r;
    sh_nxt      = sh_r;
    idx_nxt     = idx_r;
    v_nxt       = v_r;
    wprod_nxt   = wprod_r;
    wsum_nxt    = wsum_r;
    total_nxt   = total_r;
    count_nxt   = count_r;
    online_nxt  = online_r;
    pos_nxt     = pos_r;
    flag_nxt    = flag_r;
    entered_nxt = entered_r;
    dnum_nxt    = dnum_r;
    dden_nxt    = dden_r;
    dstart_nxt  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (ctl.start) begin
          sh_nxt     = frame;
          idx_nxt    = '0;
          wsum_nxt   = '0;
          total_nxt  = '0;
          count_nxt  = '0;
          online_nxt = 1'b0;
          state_nxt  = S_NORM;
        end
      end
      S_NORM: begin
        if (low_side) begin
          v_nxt     = '0;
          state_nxt = S_ACC;
        end else if (diff >= span) begin
          v_nxt     = lspe_pkg::NORM_W'(lspe_pkg::NORM_FULL);
          state_nxt = S_ACC;
        end else begin
          dnum_nxt   = lspe_pkg::NUM_W'(diff) * lspe_pkg::NUM_W'(lspe_pkg::NORM_FULL);
          dden_nxt   = span;
          dstart_nxt = 1'b1;
          state_nxt  = S_WAITN;
        end
      end
      S_WAITN: begin
        if (div_rsp.done) begin
          v_nxt     = div_rsp.quo[lspe_pkg::NORM_W-1:0];
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        wprod_nxt = '0;
        if (v_r > cfg.weight_thr) begin
          wprod_nxt = lspe_pkg::WSUM_W'(v_r) *
                      lspe_pkg::WSUM_W'(lspe_pkg::sensor_weight(idx_r));
          total_nxt = total_r + lspe_pkg::TOTAL_W'(v_r);
        end
        if (v_r > cfg.online_thr) begin
          online_nxt = 1'b1;
        end
        if (v_r > cfg.detect_thr) begin
          count_nxt = count_r + 1'b1;
        end
        state_nxt = S_ADD;
      end
      S_ADD: begin
        wsum_nxt = wsum_r + wprod_r;
        sh_nxt   = sh_r >> lspe_pkg::RAW_WIDTH;
        idx_nxt  = idx_r + 1'b1;
        state_nxt = (idx_r == lspe_pkg::IDX_W'(lspe_pkg::SENSOR_COUNT - 1)) ? S_FIN : S_NORM;
      end
      S_FIN: begin
        if (count_r == lspe_pkg::CNT_W'(lspe_pkg::SENSOR_COUNT)) begin
          flag_nxt    = 1'b1;
          entered_nxt = !flag_r;
        end else begin
          flag_nxt    = 1'b0;
          entered_nxt = 1'b0;
        end
        if (!online_r) begin
          pos_nxt   = (pos_r < lspe_pkg::POS_W'(lspe_pkg::POS_MID))
                      ? '0 : lspe_pkg::POS_W'(lspe_pkg::POS_FULL);
          state_nxt = S_DONE;
        end else if (total_r != '0) begin
          dnum_nxt   = lspe_pkg::NUM_W'(wsum_r);
          dden_nxt   = lspe_pkg::DEN_W'(total_r);
          dstart_nxt = 1'b1;
          state_nxt  = S_WAITP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_WAITP: begin
        if (div_rsp.done) begin
          pos_nxt   = div_rsp.quo;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (ctl.ack) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pos_r    <= '0;
      flag_r   <= 1'b0;
      dstart_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      flag_r   <= flag_nxt;
      dstart_r <= dstart_nxt;
    end
    sh_r      <= sh_nxt;
    idx_r     <= idx_nxt;
    v_r       <= v_nxt;
    wprod_r   <= wprod_nxt;
    wsum_r    <= wsum_nxt;
    total_r   <= total_nxt;
    count_r   <= count_nxt;
    online_r  <= online_nxt;
    entered_r <= entered_nxt;
    dnum_r    <= dnum_nxt;
    dden_r    <= dden_nxt;
  end

  assign div_req.start = dstart_r;
  assign div_req.num   = dnum_r;
  assign div_req.den   = dden_r;

  assign res_valid               = (state_r == S_DONE);
  assign result.line_position    = pos_r;
  assign result.on_line          = online_r;
  assign result.detect_count     = count_r;
  assign result.at_crossing      = flag_r;
  assign result.crossing_entered = entered_r;

endmodule

`default_nettype wire

[hw/rtl/line_sensor_position_estimator_unit.sv]
// ----------------------------------------------------------------------------
// line_sensor_position_estimator_unit: weighted line position from 8 readings
// Each frame uses the shared serial divider once per normalized reading that is
// not clamped, and once more for the average when on line with nonzero total.
// One frame in flight; a new request is taken the cycle after the result is
// registered, which waits until the result side is ready.
// Synchronous reset: calibration defaults, position 0, crossing flag clear.
// ----------------------------------------------------------------------------
`default_nettype none

module line_sensor_position_estimator_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire lspe_pkg::in_payload_t               in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output lspe_pkg::out_payload_t                   out_data,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [lspe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [lspe_pkg::CFG_DATA_W-1:0]     cfg_data
);

  lspe_pkg::cfg_t         cfg_r;
  lspe_pkg::out_payload_t out_data_r;
  lspe_pkg::out_payload_t result;
  lspe_pkg::seq_ctl_t     ctl;
  lspe_pkg::div_req_t     div_req;
  lspe_pkg::div_rsp_t     div_rsp;
  logic                   out_valid_r;
  logic                   busy_r;
  logic                   res_valid;

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy_r;
  assign ctl.start = in_valid && in_ready;
  assign ctl.ack   = res_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cal_min    <= lspe_pkg::CAL_MIN_RST;
      cfg_r.cal_max    <= lspe_pkg::CAL_MAX_RST;
      cfg_r.online_thr <= lspe_pkg::ONLINE_THR_RST;
      cfg_r.weight_thr <= lspe_pkg::WEIGHT_THR_RST;
      cfg_r.detect_thr <= lspe_pkg::DETECT_THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lspe_pkg::CFG_CAL_MIN:    cfg_r.cal_min    <= cfg_data;
        lspe_pkg::CFG_CAL_MAX:    cfg_r.cal_max    <= cfg_data;
        lspe_pkg::CFG_ONLINE_THR: cfg_r.online_thr <= cfg_data[lspe_pkg::THR_W-1:0];
        lspe_pkg::CFG_WEIGHT_THR: cfg_r.weight_thr <= cfg_data[lspe_pkg::THR_W-1:0];
        lspe_pkg::CFG_DETECT_THR: cfg_r.detect_thr <= cfg_data[lspe_pkg::THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.start) begin
        busy_r <= 1'b1;
      end else if (ctl.ack) begin
        busy_r <= 1'b0;
      end
      if (ctl.ack) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (ctl.ack) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  lspe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  lspe_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .frame     (in_data),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .result    (result),
    .div_req   (div_req),
    .div_rsp   (div_rsp)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted but block not busy");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.line_position <= lspe_pkg::POS_W'(lspe_pkg::POS_FULL))
    else $error("line position out of range");

  a_entered_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.crossing_entered |-> out_data.at_crossing)
    else $error("crossing entry without crossing flag");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.detect_count <= lspe_pkg::CNT_W'(lspe_pkg::SENSOR_COUNT))
    else $error("detect count out of range");

endmodule

`default_nettype wire

[bench/lspe_result_checker.sv]
// ----------------------------------------------------------------------------
// lspe_result_checker: result predictor and comparator for the estimator
// Follows register writes and accepted frames, predicts each result with
// its own copy of the calibration, position and crossing state, and compares
// every accepted result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module lspe_result_checker
  import lspe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_payload_t           in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_payload_t          out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int unsigned           fail_count,
  output int unsigned           pending
);

  localparam int unsigned POS_SAT = (1 << POS_W) - 1;

  logic [CAL_W-1:0] cal_lo;
  logic [CAL_W-1:0] cal_hi;
  logic [THR_W-1:0] online_lvl;
  logic [THR_W-1:0] weight_lvl;
  logic [THR_W-1:0] detect_lvl;
  int unsigned      track_pos;
  logic             crossing_held;

  out_payload_t expected_estimates[$];

  initial fail_count = 0;
  initial pending = 0;

  function automatic int unsigned scale_reading(input logic [RAW_WIDTH-1:0] raw);
    int unsigned q;
    if (cal_hi <= cal_lo || raw <= cal_lo) return 0;
    q = ((int'(raw) - int'(cal_lo)) * NORM_FULL) / (int'(cal_hi) - int'(cal_lo));
    if (q > NORM_FULL) q = NORM_FULL;
    return q;
  endfunction

  task automatic estimate_frame(input in_payload_t f);
    int unsigned  lvl;
    int unsigned  wsum;
    int unsigned  total;
    int unsigned  hits;
    logic         seen;
    logic         entered;
    out_payload_t r;
    wsum    = 0;
    total   = 0;
    hits    = 0;
    seen    = 1'b0;
    entered = 1'b0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      lvl = scale_reading(f[i*RAW_WIDTH +: RAW_WIDTH]);
      if (lvl > online_lvl) seen = 1'b1;
      if (lvl > weight_lvl) begin
        wsum  += lvl * (i * NORM_FULL);
        total += lvl;
      end
      if (lvl > detect_lvl) hits++;
    end
    if (!seen) begin
      track_pos = (track_pos < POS_MID) ? 0 : POS_FULL;
    end else if (total != 0) begin
      track_pos = wsum / total;
    end
    if (track_pos > POS_SAT) track_pos = POS_SAT;
    if (hits == SENSOR_COUNT) begin
      entered       = !crossing_held;
      crossing_held = 1'b1;
    end else begin
      crossing_held = 1'b0;
    end
    r.line_position    = track_pos[POS_W-1:0];
    r.on_line          = seen;
    r.detect_count     = hits[CNT_W-1:0];
    r.at_crossing      = crossing_held;
    r.crossing_entered = entered;
    expected_estimates.push_back(r);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_payload_t want;
    if (!rst_n) begin
      cal_lo        = CAL_MIN_RST;
      cal_hi        = CAL_MAX_RST;
      online_lvl    = ONLINE_THR_RST;
      weight_lvl    = WEIGHT_THR_RST;
      detect_lvl    = DETECT_THR_RST;
      track_pos     = 0;
      crossing_held = 1'b0;
      expected_estimates.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CAL_MIN:    cal_lo     = cfg_data[CAL_W-1:0];
          CFG_CAL_MAX:    cal_hi     = cfg_data[CAL_W-1:0];
          CFG_ONLINE_THR: online_lvl = cfg_data[THR_W-1:0];
          CFG_WEIGHT_THR: weight_lvl = cfg_data[THR_W-1:0];
          CFG_DETECT_THR: detect_lvl = cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) estimate_frame(in_data);
      if (out_valid && out_ready) begin
        if (expected_estimates.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          want = expected_estimates.pop_front();
          check_field("line_position", want.line_position, out_data.line_position);
          check_field("on_line", want.on_line, out_data.on_line);
          check_field("detect_count", want.detect_count, out_data.detect_count);
          check_field("at_crossing", want.at_crossing, out_data.at_crossing);
          check_field("crossing_entered", want.crossing_entered,
                      out_data.crossing_entered);
        end
      end
    end
    pending = expected_estimates.size();
  end

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: line sensor position estimator testbench
// Directed frames cover calibration edges, snapping, held position and the
// crossing flag; then random phases of line-shaped, crossing, blank and noise
// frames under several register settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import lspe_pkg::*;

  localparam int unsigned QUIET_CYCLES = 200;
  localparam int unsigned PHASE_FRAMES = 170;
  localparam longint      RAW_MAX      = (longint'(1) << RAW_WIDTH) - 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SPARE = CFG_DETECT_THR + CFG_IDX_W'(1);

  typedef enum logic [1:0] {FR_NOISE, FR_LINE, FR_CROSS, FR_BLANK} frame_kind_e;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_payload_t           in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_payload_t          out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  idle_on   = 1'b1;
  int unsigned           fail_count;
  int unsigned           pending;

  int          span_lo = CAL_MIN_RST;
  int          span_hi = CAL_MAX_RST;
  frame_kind_e kind    = FR_LINE;

  always #1 clk = ~clk;

  line_sensor_position_estimator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lspe_result_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(negedge clk) begin
    out_ready <= !idle_on || ($urandom_range(99) >= 33);
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic in_payload_t uniform(input logic [RAW_WIDTH-1:0] raw);
    in_payload_t f;
    for (int i = 0; i < SENSOR_COUNT; i++) f[i*RAW_WIDTH +: RAW_WIDTH] = raw;
    return f;
  endfunction

  // raw reading that lands near a normalized level under the current span
  function automatic logic [RAW_WIDTH-1:0] raw_at(input int unsigned lvl);
    longint v;
    if (span_hi <= span_lo) return RAW_WIDTH'($urandom);
    v = longint'(span_lo) + (longint'(span_hi - span_lo) * lvl) / NORM_FULL +
        longint'($urandom_range(8)) - 4;
    if (v < 0) v = 0;
    if (v > RAW_MAX) v = RAW_MAX;
    return RAW_WIDTH'(v);
  endfunction

  function automatic in_payload_t random_frame(input frame_kind_e k);
    in_payload_t f;
    int          c;
    int          w;
    int          d;
    int unsigned lvl;
    c = $urandom_range(POS_FULL);
    w = $urandom_range(500, 1600);
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      case (k)
        FR_NOISE: begin
          case ($urandom_range(3))
            0: f[i*RAW_WIDTH +: RAW_WIDTH] = RAW_WIDTH'($urandom);
            1: f[i*RAW_WIDTH +: RAW_WIDTH] = '0;
            2: f[i*RAW_WIDTH +: RAW_WIDTH] = '1;
            default: f[i*RAW_WIDTH +: RAW_WIDTH] = raw_at($urandom_range(1200));
          endcase
        end
        FR_LINE: begin
          d = i * NORM_FULL - c;
          if (d < 0) d = -d;
          lvl = (d >= w) ? $urandom_range(120) : NORM_FULL - (d * NORM_FULL) / w;
          f[i*RAW_WIDTH +: RAW_WIDTH] = raw_at(lvl + $urandom_range(100));
        end
        FR_CROSS: f[i*RAW_WIDTH +: RAW_WIDTH] = raw_at($urandom_range(850, 1200));
        default:  f[i*RAW_WIDTH +: RAW_WIDTH] = raw_at($urandom_range(150));
      endcase
    end
    return f;
  endfunction

  task automatic send_frame(input in_payload_t f);
    while (idle_on && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data  <= f;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] lo, hi, on_t, wt_t, det_t);
    wait_quiet();
    write_reg(CFG_CAL_MIN, lo);
    write_reg(CFG_CAL_MAX, hi);
    write_reg(CFG_ONLINE_THR, on_t);
    write_reg(CFG_WEIGHT_THR, wt_t);
    write_reg(CFG_DETECT_THR, det_t);
    write_reg(CFG_FIRST_SPARE + CFG_IDX_W'($urandom_range(2)), CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    span_lo = lo;
    span_hi = hi;
  endtask

  initial begin
    in_payload_t f;
    int unsigned pick;
    int          lo;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset calibration: blank, crossing enter/hold/clear, edges, snapping
    send_frame(uniform('0));
    send_frame(uniform('1));
    send_frame(uniform('1));
    f = uniform(CAL_MIN_RST);
    f.raw_0 = CAL_MAX_RST;
    f.raw_1 = CAL_MAX_RST;
    f.raw_2 = CAL_MAX_RST;
    f.raw_3 = CAL_MAX_RST;
    send_frame(f);
    send_frame(uniform('0));
    f = uniform('0);
    f.raw_7 = CAL_MAX_RST;
    send_frame(f);
    send_frame(uniform('0));
    f = uniform('0);
    f.raw_3 = CAL_MAX_RST;
    f.raw_4 = CAL_MAX_RST;
    send_frame(f);
    send_frame(uniform('0));
    f = uniform(CAL_MIN_RST + CAL_W'(1));
    f.raw_1 = CAL_MAX_RST - CAL_W'(1);
    send_frame(f);
    send_frame({4{16'hA5A5, 16'h5A5A}});

    // weight threshold above online threshold: position held
    program_regs(CAL_MIN_RST, CAL_MAX_RST, 200, 900, 600);
    f = uniform('0);
    f.raw_2 = '1;
    send_frame(f);
    send_frame(uniform(raw_at(500)));

    // inverted and empty span
    program_regs(16'hFFFF, 16'h0000, CFG_DATA_W'(ONLINE_THR_RST),
                 CFG_DATA_W'(WEIGHT_THR_RST), CFG_DATA_W'(DETECT_THR_RST));
    send_frame(uniform('1));
    program_regs(16'd1000, 16'd1000, CFG_DATA_W'(ONLINE_THR_RST),
                 CFG_DATA_W'(WEIGHT_THR_RST), CFG_DATA_W'(DETECT_THR_RST));
    send_frame(uniform('1));

    // full span, zero thresholds
    program_regs(16'h0000, 16'hFFFF, 0, 0, 0);
    send_frame(uniform(16'd1));
    send_frame(uniform(16'd66));
    for (int i = 0; i < SENSOR_COUNT; i++) f[i*RAW_WIDTH +: RAW_WIDTH] = RAW_WIDTH'(i * 9362);
    send_frame(f);
    send_frame(uniform('1));

    // thresholds at and above full scale
    program_regs(CAL_MIN_RST, CAL_MAX_RST, 1000, 1000, 16'h03FF);
    send_frame(uniform('1));

    for (int ph = 0; ph < 6; ph++) begin
      idle_on <= (ph != 2);
      case (ph)
        0: program_regs(CAL_MIN_RST, CAL_MAX_RST, CFG_DATA_W'(ONLINE_THR_RST),
                        CFG_DATA_W'(WEIGHT_THR_RST), CFG_DATA_W'(DETECT_THR_RST));
        1: begin
          lo = $urandom_range(3000);
          program_regs(CFG_DATA_W'(lo), CFG_DATA_W'(lo + $urandom_range(500, 20000)),
                       CFG_DATA_W'($urandom_range(50, 500)),
                       CFG_DATA_W'($urandom_range(400)),
                       CFG_DATA_W'($urandom_range(300, 900)));
        end
        2: program_regs(16'h0000, 16'hFFFF, 0, 0, 1000);
        3: program_regs(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                        CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
        4: begin
          lo = $urandom_range(2000);
          program_regs(CFG_DATA_W'(lo), CFG_DATA_W'(lo + $urandom_range(1000, 8000)),
                       CFG_DATA_W'($urandom_range(100, 1023)),
                       CFG_DATA_W'($urandom_range(1023)),
                       CFG_DATA_W'($urandom_range(500, 1023)));
        end
        default: program_regs(16'hFFFE, 16'hFFFF, CFG_DATA_W'($urandom_range(1000)),
                              CFG_DATA_W'($urandom_range(1000)),
                              CFG_DATA_W'($urandom_range(1000)));
      endcase
      repeat (PHASE_FRAMES) begin
        if ($urandom_range(99) >= 40) begin
          pick = $urandom_range(99);
          kind = (pick < 15) ? FR_NOISE : (pick < 70) ? FR_LINE :
                 (pick < 85) ? FR_CROSS : FR_BLANK;
        end
        send_frame(random_frame(kind));
      end
    end

    wait_quiet();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
